>>> hw/rtl/cle_pkg.sv
// Shared constants, types and structs for the console line editor and tokenizer.
`timescale 1ns / 1ps

package cle_pkg;

    localparam int LINE_CAPACITY = 512;
    localparam int MAX_ARGS      = 10;

    localparam int PW      = $clog2(LINE_CAPACITY);
    localparam int ARGN_W  = $clog2(MAX_ARGS + 1);

    localparam int W_KIND  = 1;
    localparam int W_BYTE  = 8;
    localparam int W_IDX   = 9;
    localparam int W_RKIND = 3;
    localparam int W_POS   = 9;
    localparam int W_TNUM  = 4;
    localparam int W_ARGC  = 4;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DEL   = 8'd127;

    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef logic [PW-1:0]     t_pos;
    typedef logic [ARGN_W-1:0] t_argn;

    typedef enum logic [W_RKIND-1:0] {
        RK_ECHO     = 3'd0,
        RK_TOKEN    = 3'd1,
        RK_SUMMARY  = 3'd2,
        RK_TOO_MANY = 3'd3,
        RK_READ     = 3'd4
    } t_rkind;

    typedef enum logic [1:0] {
        MD_SKIP,
        MD_WORD,
        MD_QUOTE
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ECHO_CH,
        ST_ECHO_SP,
        ST_ECHO_END,
        ST_LINE_ECHO,
        ST_FETCH,
        ST_EVAL,
        ST_TOKEN,
        ST_SUMMARY
    } t_state;

    typedef struct packed {
        t_mode      mode;
        t_pos       pos;
        t_pos       start;
        logic [7:0] ch;
        logic       at_end;
    } t_step_in;

    typedef struct packed {
        t_mode mode;
        t_pos  start;
        logic  advance;
        logic  emit;
        logic  stop;
    } t_step_out;

    typedef struct packed {
        t_rkind              result_kind;
        logic [W_BYTE-1:0]   out_byte;
        logic [W_POS-1:0]    token_start;
        logic [W_POS-1:0]    token_length;
        logic [W_TNUM-1:0]   token_number;
        logic [W_ARGC-1:0]   argument_count;
        logic                has_command;
        logic                last;
    } t_result;

endpackage

>>> hw/rtl/cle_if.sv
// Request and result channel interfaces of the console line editor.
`timescale 1ns / 1ps

interface cle_in_if;
    logic                       valid;
    logic                       ready;
    logic [cle_pkg::W_KIND-1:0] kind;
    logic [cle_pkg::W_BYTE-1:0] rx_byte;
    logic [cle_pkg::W_IDX-1:0]  read_index;

    modport source (output valid, output kind, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input kind, input rx_byte, input read_index,
                    output ready);
endinterface

interface cle_out_if;
    logic                        valid;
    logic                        ready;
    logic [cle_pkg::W_RKIND-1:0] result_kind;
    logic [cle_pkg::W_BYTE-1:0]  out_byte;
    logic [cle_pkg::W_POS-1:0]   token_start;
    logic [cle_pkg::W_POS-1:0]   token_length;
    logic [cle_pkg::W_TNUM-1:0]  token_number;
    logic [cle_pkg::W_ARGC-1:0]  argument_count;
    logic                        has_command;
    logic                        last;

    modport source (output valid, output result_kind, output out_byte,
                    output token_start, output token_length, output token_number,
                    output argument_count, output has_command, output last,
                    input ready);
    modport sink   (input valid, input result_kind, input out_byte,
                    input token_start, input token_length, input token_number,
                    input argument_count, input has_command, input last,
                    output ready);
endinterface

>>> hw/rtl/cle_step.sv
// Token scanner step: classifies one line character and advances the scan mode.
`timescale 1ns / 1ps

module cle_step (
    input  cle_pkg::t_step_in  i_step,
    output cle_pkg::t_step_out o_step
);
    import cle_pkg::*;

    logic w_gap;
    logic w_quote;

    always_comb begin
        w_gap   = i_step.ch inside {CH_SPACE, CH_TAB};
        w_quote = (i_step.ch == CH_QUOTE);

        o_step.mode    = i_step.mode;
        o_step.start   = i_step.start;
        o_step.advance = 1'b0;
        o_step.emit    = 1'b0;
        o_step.stop    = 1'b0;

        if (i_step.at_end) begin
            o_step.emit = (i_step.mode != MD_SKIP) && (i_step.pos != i_step.start);
            o_step.stop = 1'b1;
        end else begin
            o_step.advance = 1'b1;
            case (i_step.mode)
                MD_SKIP: begin
                    if (w_quote) begin
                        o_step.mode  = MD_QUOTE;
                        o_step.start = i_step.pos + 1'b1;
                    end else if (!w_gap) begin
                        o_step.mode  = MD_WORD;
                        o_step.start = i_step.pos;
                    end
                end
                MD_WORD: begin
                    if (w_gap) begin
                        o_step.emit = 1'b1;
                        o_step.mode = MD_SKIP;
                    end
                end
                MD_QUOTE: begin
                    if (w_quote) begin
                        if (i_step.pos != i_step.start) begin
                            o_step.emit = 1'b1;
                            o_step.mode = MD_SKIP;
                        end else begin
                            o_step.stop    = 1'b1;
                            o_step.advance = 1'b0;
                        end
                    end
                end
                default: begin
                    o_step.mode = MD_SKIP;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/console_line_editor_tokenizer_top.sv
// Top level of the console line editor with line store and quoted-token scanner.
`timescale 1ns / 1ps

// Channel  | Port  | Direction | Contents
// request  | i_req | sink      | kind, rx_byte, read_index
// result   | o_res | source    | result_kind, out_byte, token fields, summary, last
//
// One request at a time; i_req.ready is high only while the sequencer is idle.
// Read back and edit requests can be held by output stalls.
// End of line: echo, then the line store is read character by character through a
// single registered read port. No clearing pass: the scanner evaluates bytes
// below the line length only, but read back is not limited to the fill count.
// A stalled result holds the sequencer; reset empties the line.

module console_line_editor_tokenizer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cle_in_if.sink    i_req,
    cle_out_if.source o_res
);
    import cle_pkg::*;

    t_state r_state, n_state;

    t_pos    r_fill, n_fill;
    logic [7:0] r_ch, n_ch;
    t_pos    r_len, n_len;
    t_pos    r_pos, n_pos;
    t_pos    r_start, n_start;
    t_mode   r_mode, n_mode;
    logic    r_first, n_first;
    t_argn   r_nargs, n_nargs;
    logic    r_hascmd, n_hascmd;
    logic    r_stop, n_stop;
    t_pos    r_tstart, n_tstart;
    t_pos    r_tlen, n_tlen;
    logic    r_rd_oob, n_rd_oob;

    logic [7:0] r_mem [LINE_CAPACITY];
    logic [7:0] r_rd_data;
    logic       w_rd_en;
    t_pos       w_rd_addr;
    logic       w_wr_en;
    t_pos       w_wr_addr;
    logic [7:0] w_wr_data;

    t_result r_res;
    t_result w_res;
    logic    r_out_valid;
    logic    w_emit;
    logic    w_slot;
    logic    w_acc;

    logic w_is_bs;
    logic w_is_eol;
    logic w_is_print;
    logic w_room;
    logic w_at_len;
    logic w_args_full;

    t_step_in  w_step_in;
    t_step_out w_step_out;

    cle_step u_step (
        .i_step (w_step_in),
        .o_step (w_step_out)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_slot      = !r_out_valid || o_res.ready;
    assign w_room      = (r_fill != PW'(LINE_CAPACITY - 1));
    assign w_at_len    = (r_pos == r_len);
    assign w_args_full = (r_nargs == ARGN_W'(MAX_ARGS));

    always_comb begin
        w_is_bs    = 1'b0;
        w_is_eol   = 1'b0;
        w_is_print = 1'b0;
        case (i_req.rx_byte) inside
            CH_BS, CH_DEL: begin
                w_is_bs = 1'b1;
            end
            CH_LF, CH_CR: begin
                w_is_eol = 1'b1;
            end
            [CH_SPACE:8'hFF]: begin
                w_is_print = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_step_in.mode   = r_mode;
        w_step_in.pos    = r_pos;
        w_step_in.start  = r_start;
        w_step_in.ch     = r_rd_data;
        w_step_in.at_end = (r_state == ST_FETCH);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_req.kind == KIND_READ) begin
                        n_state = ST_READ;
                    end else if (w_is_bs && (r_fill != '0)) begin
                        n_state = ST_ECHO_CH;
                    end else if (w_is_eol) begin
                        n_state = ST_LINE_ECHO;
                    end else if (w_is_print && w_room) begin
                        n_state = ST_ECHO_END;
                    end
                end
            end
            ST_READ, ST_ECHO_END, ST_SUMMARY: begin
                if (w_slot) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ECHO_CH: begin
                if (w_slot) begin
                    n_state = ST_ECHO_SP;
                end
            end
            ST_ECHO_SP: begin
                if (w_slot) begin
                    n_state = ST_ECHO_END;
                end
            end
            ST_LINE_ECHO: begin
                if (w_slot) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (!w_at_len) begin
                    n_state = ST_EVAL;
                end else if (w_step_out.emit) begin
                    n_state = ST_TOKEN;
                end else begin
                    n_state = ST_SUMMARY;
                end
            end
            ST_EVAL: begin
                if (w_step_out.emit) begin
                    n_state = ST_TOKEN;
                end else if (w_step_out.stop) begin
                    n_state = ST_SUMMARY;
                end else if (t_pos'(r_pos + 1'b1) == r_len) begin
                    n_state = ST_FETCH;
                end
            end
            ST_TOKEN: begin
                if (w_slot) begin
                    if ((!r_first && w_args_full) || r_stop) begin
                        n_state = ST_SUMMARY;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb begin
        n_fill    = r_fill;
        n_ch      = r_ch;
        n_len     = r_len;
        n_pos     = r_pos;
        n_start   = r_start;
        n_mode    = r_mode;
        n_first   = r_first;
        n_nargs   = r_nargs;
        n_hascmd  = r_hascmd;
        n_stop    = r_stop;
        n_tstart  = r_tstart;
        n_tlen    = r_tlen;
        n_rd_oob  = r_rd_oob;
        w_rd_en   = 1'b0;
        w_rd_addr = r_pos;
        w_wr_en   = 1'b0;
        w_wr_addr = r_fill;
        w_wr_data = '0;
        w_emit    = 1'b0;
        w_res     = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_req.kind == KIND_READ) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = PW'(i_req.read_index);
                        n_rd_oob  = (32'(i_req.read_index) >= LINE_CAPACITY);
                    end else if (w_is_bs) begin
                        if (r_fill != '0) begin
                            n_fill = r_fill - 1'b1;
                            n_ch   = i_req.rx_byte;
                        end
                    end else if (w_is_eol) begin
                        w_wr_en = 1'b1;
                        n_ch    = i_req.rx_byte;
                        n_len   = r_fill;
                        n_fill  = '0;
                    end else if (w_is_print && w_room) begin
                        w_wr_en   = 1'b1;
                        w_wr_data = i_req.rx_byte;
                        n_fill    = r_fill + 1'b1;
                        n_ch      = i_req.rx_byte;
                    end
                end
            end
            ST_READ: begin
                w_emit            = w_slot;
                w_res.result_kind = RK_READ;
                w_res.out_byte    = r_rd_oob ? 8'd0 : r_rd_data;
                w_res.last        = 1'b1;
            end
            ST_ECHO_CH: begin
                w_emit            = w_slot;
                w_res.result_kind = RK_ECHO;
                w_res.out_byte    = r_ch;
            end
            ST_ECHO_SP: begin
                w_emit            = w_slot;
                w_res.result_kind = RK_ECHO;
                w_res.out_byte    = CH_SPACE;
            end
            ST_ECHO_END: begin
                w_emit            = w_slot;
                w_res.result_kind = RK_ECHO;
                w_res.out_byte    = r_ch;
                w_res.last        = 1'b1;
            end
            ST_LINE_ECHO: begin
                w_emit            = w_slot;
                w_res.result_kind = RK_ECHO;
                w_res.out_byte    = r_ch;
                if (w_slot) begin
                    n_pos    = '0;
                    n_start  = '0;
                    n_mode   = MD_SKIP;
                    n_first  = 1'b1;
                    n_nargs  = '0;
                    n_hascmd = 1'b0;
                    n_stop   = 1'b0;
                end
            end
            ST_FETCH: begin
                if (w_at_len) begin
                    n_tstart = r_start;
                    n_tlen   = r_pos - r_start;
                    n_stop   = 1'b1;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_pos;
                end
            end
            ST_EVAL: begin
                n_mode    = w_step_out.mode;
                n_start   = w_step_out.start;
                n_tstart  = r_start;
                n_tlen    = r_pos - r_start;
                n_stop    = w_step_out.stop;
                w_rd_en   = 1'b1;
                w_rd_addr = r_pos + 1'b1;
                if (w_step_out.advance) begin
                    n_pos = r_pos + 1'b1;
                end
            end
            ST_TOKEN: begin
                w_emit = w_slot;
                if (r_first) begin
                    w_res.result_kind  = RK_TOKEN;
                    w_res.token_start  = W_POS'(r_tstart);
                    w_res.token_length = W_POS'(r_tlen);
                    if (w_slot) begin
                        n_first  = 1'b0;
                        n_hascmd = 1'b1;
                    end
                end else if (w_args_full) begin
                    w_res.result_kind = RK_TOO_MANY;
                    if (w_slot) begin
                        n_hascmd = 1'b0;
                    end
                end else begin
                    w_res.result_kind  = RK_TOKEN;
                    w_res.token_start  = W_POS'(r_tstart);
                    w_res.token_length = W_POS'(r_tlen);
                    w_res.token_number = W_TNUM'(t_argn'(r_nargs + 1'b1));
                    if (w_slot) begin
                        n_nargs = r_nargs + 1'b1;
                    end
                end
            end
            ST_SUMMARY: begin
                w_emit               = w_slot;
                w_res.result_kind    = RK_SUMMARY;
                w_res.argument_count = W_ARGC'(r_nargs);
                w_res.has_command    = r_hascmd;
                w_res.last           = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch     <= n_ch;
        r_len    <= n_len;
        r_pos    <= n_pos;
        r_start  <= n_start;
        r_mode   <= n_mode;
        r_first  <= n_first;
        r_nargs  <= n_nargs;
        r_hascmd <= n_hascmd;
        r_stop   <= n_stop;
        r_tstart <= n_tstart;
        r_tlen   <= n_tlen;
        r_rd_oob <= n_rd_oob;
        if (w_emit) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_kind    = r_res.result_kind;
    assign o_res.out_byte       = r_res.out_byte;
    assign o_res.token_start    = r_res.token_start;
    assign o_res.token_length   = r_res.token_length;
    assign o_res.token_number   = r_res.token_number;
    assign o_res.argument_count = r_res.argument_count;
    assign o_res.has_command    = r_res.has_command;
    assign o_res.last           = r_res.last;

endmodule

>>> hw/rtl/cle_checker.sv
// Port-level assertions for the console line editor, bound to its top level.
`timescale 1ns / 1ps

module cle_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic [cle_pkg::W_KIND-1:0]  i_req_kind,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [cle_pkg::W_RKIND-1:0] i_res_kind,
    input logic                        i_res_last
);
    import cle_pkg::*;

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("stalled result dropped");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_kind == KIND_READ) |=> !i_req_ready)
        else $error("request taken during read back");

    a_read_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_kind == RK_READ) |-> i_res_last)
        else $error("read data not marked last");

    a_token_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_kind == RK_TOKEN || i_res_kind == RK_TOO_MANY)
            |-> !i_res_last)
        else $error("token marked last");

endmodule

bind console_line_editor_tokenizer_top cle_checker u_cle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_kind  (i_req.kind),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.result_kind),
    .i_res_last  (o_res.last)
);
